>>> rtl/yuvrgb_pkg.sv
// Shared types, constants and helpers for the YUV to RGB pixel converter.
`default_nettype none

package yuvrgb_pkg;

  // Field widths
  localparam int LUMA_W   = 8;
  localparam int CHROMA_W = 8;
  localparam int DIFF_W   = 9;   // chroma minus offset, signed -255..255
  localparam int PROD_W   = 22;  // widest coefficient product, signed
  localparam int DELTA_W  = 11;  // shifted chroma term, signed -518..517
  localparam int SUM_W    = 12;  // luma plus chroma term before clamping
  localparam int SLOT_W   = 2;
  localparam int LUMA_N   = 4;
  localparam int CFG_W    = 8;   // widest configuration register
  localparam int SHIFT    = 10;

  // Fixed-point coefficients
  localparam logic signed [PROD_W-1:0] COEF_RV = 22'sd1167;
  localparam logic signed [PROD_W-1:0] COEF_GV = 22'sd595;
  localparam logic signed [PROD_W-1:0] COEF_GU = 22'sd404;
  localparam logic signed [PROD_W-1:0] COEF_BU = 22'sd2080;

  localparam logic [CHROMA_W-1:0] CHROMA_OFFSET_RESET = 8'd128;
  localparam logic [LUMA_W-1:0]   CHAN_MAX            = 8'hFF;
  localparam logic [LUMA_W-1:0]   CHAN_MIN            = 8'h00;
  localparam logic [SLOT_W-1:0]   SLOT_LAST_FOUR      = 2'd3;
  localparam logic [SLOT_W-1:0]   SLOT_LAST_TWO       = 2'd1;
  localparam logic [SLOT_W-1:0]   SLOT_FIRST          = 2'd0;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FOUR_LUMA     = 2'd0,
    REG_CHROMA_OFFSET = 2'd1,
    REG_ALPHA_ENABLE  = 2'd2
  } reg_index_t;

  // One classified word handed from the front to the back
  typedef struct packed {
    logic [LUMA_N-1:0][LUMA_W-1:0] luma;
    logic signed [DELTA_W-1:0]     dr;
    logic signed [DELTA_W-1:0]     dg;
    logic signed [DELTA_W-1:0]     db;
    logic                          four;
    logic                          alpha;
  } job_t;

  // Queue status seen by the back
  typedef struct packed {
    logic empty;
  } queue_flags_t;

  // Saturate a signed sum to one 8-bit channel
  function automatic logic [LUMA_W-1:0] clamp8(input logic signed [SUM_W-1:0] x);
    logic [LUMA_W-1:0] r;
    if (x <= 0) begin
      r = CHAN_MIN;
    end else if (x >= $signed({4'd0, CHAN_MAX})) begin
      r = CHAN_MAX;
    end else begin
      r = x[LUMA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/yuvrgb_front.sv
// Front: configuration registers, word intake and chroma term computation.
`default_nettype none

module yuvrgb_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]    luma_a,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]    luma_b,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]    luma_c,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]    luma_d,
  input  wire logic [yuvrgb_pkg::CHROMA_W-1:0]  chroma_u,
  input  wire logic [yuvrgb_pkg::CHROMA_W-1:0]  chroma_v,
  input  wire logic                             wr_en,
  input  wire logic [1:0]                       wr_index,
  input  wire logic [yuvrgb_pkg::CFG_W-1:0]     wr_data,
  output      logic                             stage_valid,
  output      logic                             q_wr,
  output      yuvrgb_pkg::job_t                 q_wdata
);

  logic                                   four_luma_mode;
  logic [yuvrgb_pkg::CHROMA_W-1:0]        chroma_offset;
  logic                                   alpha_enable;

  logic signed [yuvrgb_pkg::DIFF_W-1:0]   u_diff;
  logic signed [yuvrgb_pkg::DIFF_W-1:0]   v_diff;
  logic [yuvrgb_pkg::LUMA_N-1:0][yuvrgb_pkg::LUMA_W-1:0] luma;
  logic                                   four;
  logic                                   alpha;

  logic signed [yuvrgb_pkg::PROD_W-1:0]   u_ext;
  logic signed [yuvrgb_pkg::PROD_W-1:0]   v_ext;
  logic signed [yuvrgb_pkg::PROD_W-1:0]   prod_r;
  logic signed [yuvrgb_pkg::PROD_W-1:0]   prod_g;
  logic signed [yuvrgb_pkg::PROD_W-1:0]   prod_b;
  logic signed [yuvrgb_pkg::PROD_W-1:0]   shr_r;
  logic signed [yuvrgb_pkg::PROD_W-1:0]   shr_g;
  logic signed [yuvrgb_pkg::PROD_W-1:0]   shr_b;

  // Configuration writes and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      four_luma_mode <= 1'b1;
      chroma_offset  <= yuvrgb_pkg::CHROMA_OFFSET_RESET;
      alpha_enable   <= 1'b0;
      stage_valid    <= 1'b0;
    end else begin
      stage_valid <= accept;
      if (wr_en) begin
        unique case (yuvrgb_pkg::reg_index_t'(wr_index))
          yuvrgb_pkg::REG_FOUR_LUMA:     four_luma_mode <= wr_data[0];
          yuvrgb_pkg::REG_CHROMA_OFFSET: chroma_offset  <= wr_data;
          yuvrgb_pkg::REG_ALPHA_ENABLE:  alpha_enable   <= wr_data[0];
          default: ;
        endcase
      end
    end
  end

  // Capture the word with offset removed
  always_ff @(posedge clk) begin
    if (accept) begin
      u_diff <= $signed({1'b0, chroma_u}) - $signed({1'b0, chroma_offset});
      v_diff <= $signed({1'b0, chroma_v}) - $signed({1'b0, chroma_offset});
      luma   <= {luma_d, luma_c, luma_b, luma_a};
      four   <= four_luma_mode;
      alpha  <= alpha_enable;
    end
  end

  // Coefficient products, floor shift by 10
  always_comb begin
    u_ext  = yuvrgb_pkg::PROD_W'(u_diff);
    v_ext  = yuvrgb_pkg::PROD_W'(v_diff);
    prod_r = v_ext * yuvrgb_pkg::COEF_RV;
    prod_g = v_ext * yuvrgb_pkg::COEF_GV + u_ext * yuvrgb_pkg::COEF_GU;
    prod_b = u_ext * yuvrgb_pkg::COEF_BU;
    shr_r  = prod_r >>> yuvrgb_pkg::SHIFT;
    shr_g  = prod_g >>> yuvrgb_pkg::SHIFT;
    shr_b  = prod_b >>> yuvrgb_pkg::SHIFT;
  end

  assign q_wr          = stage_valid;
  assign q_wdata.luma  = luma;
  assign q_wdata.dr    = shr_r[yuvrgb_pkg::DELTA_W-1:0];
  assign q_wdata.dg    = shr_g[yuvrgb_pkg::DELTA_W-1:0];
  assign q_wdata.db    = shr_b[yuvrgb_pkg::DELTA_W-1:0];
  assign q_wdata.four  = four;
  assign q_wdata.alpha = alpha;

endmodule

`default_nettype wire

>>> rtl/yuvrgb_queue.sv
// Short word queue between the front and the back.
`default_nettype none

module yuvrgb_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr,
  input  wire yuvrgb_pkg::job_t             wdata,
  input  wire logic                         rd,
  output      yuvrgb_pkg::job_t             rdata,
  output      logic [$clog2(DEPTH+1)-1:0]   count,
  output      yuvrgb_pkg::queue_flags_t     flags
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  yuvrgb_pkg::job_t  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

  assign rdata       = entries[rd_ptr];
  assign flags.empty = (count == '0);

endmodule

`default_nettype wire

>>> rtl/yuvrgb_back.sv
// Back: walks the luma slots of one word, one pixel per cycle while a word is held.
`default_nettype none

module yuvrgb_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire yuvrgb_pkg::queue_flags_t           q_flags,
  input  wire yuvrgb_pkg::job_t                   q_rdata,
  output      logic                               q_rd,
  output      logic                               pixel_valid,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      red,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      green,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      blue,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      alpha,
  output      logic [yuvrgb_pkg::SLOT_W-1:0]      pixel_slot,
  output      logic                               last
);

  yuvrgb_pkg::job_t                    cur;
  logic                                active;
  logic [yuvrgb_pkg::SLOT_W-1:0]       slot;

  logic [yuvrgb_pkg::SLOT_W-1:0]       last_slot;
  logic                                at_last;
  logic signed [yuvrgb_pkg::SUM_W-1:0] y_ext;
  logic signed [yuvrgb_pkg::SUM_W-1:0] sum_r;
  logic signed [yuvrgb_pkg::SUM_W-1:0] sum_g;
  logic signed [yuvrgb_pkg::SUM_W-1:0] sum_b;

  // Slot walk and next-word pop
  always_comb begin
    last_slot = cur.four ? yuvrgb_pkg::SLOT_LAST_FOUR : yuvrgb_pkg::SLOT_LAST_TWO;
    at_last   = active && (slot == last_slot);
    q_rd      = (!active || at_last) && !q_flags.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      slot   <= yuvrgb_pkg::SLOT_FIRST;
    end else if (!active || at_last) begin
      active <= !q_flags.empty;
      slot   <= yuvrgb_pkg::SLOT_FIRST;
    end else begin
      slot <= slot + yuvrgb_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_rdata;
    end
  end

  // Channel sums for the current slot
  always_comb begin
    y_ext = $signed({4'd0, cur.luma[slot]});
    sum_r = y_ext + yuvrgb_pkg::SUM_W'(cur.dr);
    sum_g = y_ext - yuvrgb_pkg::SUM_W'(cur.dg);
    sum_b = y_ext + yuvrgb_pkg::SUM_W'(cur.db);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      red        <= yuvrgb_pkg::clamp8(sum_r);
      green      <= yuvrgb_pkg::clamp8(sum_g);
      blue       <= yuvrgb_pkg::clamp8(sum_b);
      alpha      <= cur.alpha ? yuvrgb_pkg::CHAN_MAX : yuvrgb_pkg::CHAN_MIN;
      pixel_slot <= slot;
      last       <= at_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/yuv_to_rgb_pixel_converter_top.sv
// Top level of the YUV to RGB pixel converter.
//
//   channel   direction  handshake               payload
//   command   in         start / busy            luma_a..luma_d, chroma_u, chroma_v
//   pixel     out        pixel_valid strobe      red, green, blue, alpha, pixel_slot, last
//   config    in         wr_en, wr_index         wr_data (8 bits)
//
// A word yields four pixels (two in two-luma mode), one per cycle; the single-pixel
// output walk in the back bounds word throughput, and the queue holds new words while
// one is walked. The first pixel passes the front registers, a queue entry, the back's
// word register and the output register. Reset is synchronous; no clearing pass is needed.
// busy rises when the queue plus the front stage hold QUEUE_DEPTH words.
// The receiver cannot stall; pixels are shown for one cycle each.
`default_nettype none

module yuv_to_rgb_pixel_converter_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]      luma_a,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]      luma_b,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]      luma_c,
  input  wire logic [yuvrgb_pkg::LUMA_W-1:0]      luma_d,
  input  wire logic [yuvrgb_pkg::CHROMA_W-1:0]    chroma_u,
  input  wire logic [yuvrgb_pkg::CHROMA_W-1:0]    chroma_v,
  input  wire logic                               wr_en,
  input  wire logic [1:0]                         wr_index,
  input  wire logic [yuvrgb_pkg::CFG_W-1:0]       wr_data,
  output      logic                               pixel_valid,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      red,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      green,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      blue,
  output      logic [yuvrgb_pkg::LUMA_W-1:0]      alpha,
  output      logic [yuvrgb_pkg::SLOT_W-1:0]      pixel_slot,
  output      logic                               last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  logic                      accept;
  logic                      stage_valid;
  logic                      q_wr;
  logic                      q_rd;
  yuvrgb_pkg::job_t          q_wdata;
  yuvrgb_pkg::job_t          q_rdata;
  logic [CNT_W-1:0]          q_count;
  yuvrgb_pkg::queue_flags_t  q_flags;
  logic [CNT_W:0]            in_flight;

  // Credit check: words in the front stage count against queue space
  assign in_flight = (CNT_W+1)'(q_count) + (CNT_W+1)'(stage_valid);
  assign busy      = (in_flight >= (CNT_W+1)'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  yuvrgb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .luma_a      (luma_a),
    .luma_b      (luma_b),
    .luma_c      (luma_c),
    .luma_d      (luma_d),
    .chroma_u    (chroma_u),
    .chroma_v    (chroma_v),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .stage_valid (stage_valid),
    .q_wr        (q_wr),
    .q_wdata     (q_wdata)
  );

  yuvrgb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .count (q_count),
    .flags (q_flags)
  );

  yuvrgb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_flags     (q_flags),
    .q_rdata     (q_rdata),
    .q_rd        (q_rd),
    .pixel_valid (pixel_valid),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .pixel_slot  (pixel_slot),
    .last        (last)
  );

endmodule

`default_nettype wire

>>> rtl/yuvrgb_checker.sv
// Port-level checks for the YUV to RGB pixel converter, bound to the top level.
`default_nettype none

module yuvrgb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pixel_valid,
  input wire logic [7:0] alpha,
  input wire logic [1:0] pixel_slot,
  input wire logic       last
);

  // No pixel right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel strobe after reset");

  // Pixels of one word come on consecutive cycles in slot order
  a_slot_walk: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !last) |=> (pixel_valid && pixel_slot == $past(pixel_slot) + 2'd1))
    else $error("slot sequence broken");

  // A word ends on slot b or slot d only
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && last) |-> (pixel_slot == 2'd1 || pixel_slot == 2'd3))
    else $error("last marker on wrong slot");

  // A word starts on slot a
  a_first_slot: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !$past(pixel_valid && !last)) |-> (pixel_slot == 2'd0))
    else $error("word does not start at slot a");

  // Alpha is constant opaque or clear
  a_alpha_code: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (alpha == 8'h00 || alpha == 8'hFF))
    else $error("bad alpha value");

endmodule

bind yuv_to_rgb_pixel_converter_top yuvrgb_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .alpha       (alpha),
  .pixel_slot  (pixel_slot),
  .last        (last)
);

`default_nettype wire
